FILE: hw/rtl/csfw_pkg.sv
// Shared types, codes and constants for the counting semaphore with waiter queue.
`default_nettype none
package csfw_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  // Fixed field widths.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned MAX_W     = 15;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_POST   = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_TRY    = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_QUEUED   = 3'd1,
    STAT_NODATA   = 3'd2,
    STAT_ATMAX    = 3'd3,
    STAT_NEG      = 3'd4,
    STAT_NOTFOUND = 3'd5,
    STAT_FULL     = 3'd6
  } stat_e;

  // Control group broadcast to every cell of the waiter queue.
  typedef struct packed {
    logic clear;   // empty the whole queue
    logic sample;  // register each cell's compare against the incoming id
    logic pop;     // remove the head entry
    logic cancel;  // remove the oldest entry whose compare matched
    logic push;    // append the incoming id behind the last valid entry
  } qctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/csfw_cell.sv
// One queue cell: holds a waiter id and its valid bit, shifts towards the head.
`default_nettype none
module csfw_cell
  import csfw_pkg::*;
#(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qctl_t              ctl_i,
  input  wire logic [ID_BITS-1:0] id_i,
  input  wire logic               prev_valid_i,
  input  wire logic [ID_BITS-1:0] next_slot_i,
  input  wire logic               next_valid_i,
  input  wire logic               kill_i,
  output logic                    kill_o,
  output logic [ID_BITS-1:0]      slot_o,
  output logic                    valid_o
);

  logic [ID_BITS-1:0] slot_q;
  logic               valid_q;
  logic               match_q;
  logic               shift;

  // The removal point ripples towards the tail: this cell and all later ones shift.
  assign kill_o = kill_i | (ctl_i.cancel & match_q);
  assign shift  = (ctl_i.pop | ctl_i.cancel) & kill_o;

  // Valid bit: cleared on clear, refilled from the neighbour on shift, set on push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clear) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= next_valid_i;
    end else if (ctl_i.push && prev_valid_i && !valid_q) begin
      valid_q <= 1'b1;
    end
  end

  // Stored id and the registered compare used by cancel.
  always_ff @(posedge clk_i) begin
    if (shift) begin
      slot_q <= next_slot_i;
    end else if (ctl_i.push && prev_valid_i && !valid_q) begin
      slot_q <= id_i;
    end
    if (ctl_i.sample) begin
      match_q <= valid_q && (slot_q == id_i);
    end
  end

  assign slot_o  = slot_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/csfw_queue.sv
// Waiter queue: a row of cells with the oldest entry in cell zero.
`default_nettype none
module csfw_queue
  import csfw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qctl_t              ctl_i,
  input  wire logic [ID_BITS-1:0] id_i,
  output logic [ID_BITS-1:0]      head_id_o,
  output logic                    empty_o,
  output logic                    full_o,
  output logic                    found_o
);

  logic [ID_BITS-1:0] slot  [QUEUE_DEPTH];
  logic               valid [QUEUE_DEPTH];
  logic               kill  [QUEUE_DEPTH+1];

  // A pop removes from the head; a cancel starts the ripple at the first match.
  assign kill[0] = ctl_i.pop;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic               prev_valid;
    logic [ID_BITS-1:0] next_slot;
    logic               next_valid;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_slot  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_slot  = slot[i+1];
      assign next_valid = valid[i+1];
    end

    csfw_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .id_i        (id_i),
      .prev_valid_i(prev_valid),
      .next_slot_i (next_slot),
      .next_valid_i(next_valid),
      .kill_i      (kill[i]),
      .kill_o      (kill[i+1]),
      .slot_o      (slot[i]),
      .valid_o     (valid[i])
    );
  end

  assign head_id_o = slot[0];
  assign empty_o   = !valid[0];
  assign full_o    = valid[QUEUE_DEPTH-1];
  assign found_o   = kill[QUEUE_DEPTH];

endmodule
`default_nettype wire

FILE: hw/rtl/counting_semaphore_fifo_waiters.sv
// Top level of the counting semaphore with a first-in first-out waiter queue.
// Usage: commands arrive as stream requests on s_axis (cmd and waiter id), and
// each request produces exactly one result on m_axis (status, woken waiter,
// count after the command). Configuration is a plain write port: index 0
// loads the count from initial_count and empties the queue, index 1 sets
// max_count. Write configuration only while no request is in flight.
// A request is latched on accept while each queue cell registers its id
// compare; in the update state that follows, the count and the cell row are
// updated, where a removal ripples from the matching cell to the tail in one
// pass, and the result is written to the output register, raising
// m_axis_tvalid. A new request is not taken until its predecessor has left
// the update state. The input is taken again while a result is still waiting
// in the output register; if the receiver stalls, the next request is held in
// the update state until the output register frees, and s_axis_tready stays low.
// Reset empties the queue, sets the count to 0 and max_count to 1.
`default_nettype none
module counting_semaphore_fifo_waiters
  import csfw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  localparam int unsigned IN_W       = ((CMD_W + ID_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((STAT_W + 1 + ID_BITS + CNT_W + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_W-1:0]      s_axis_tdata,   // cmd, waiter_id, zero pad
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,   // status, woken_valid, woken_id,
                                                    // count_after, zero pad
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                    state_q, state_d;
  cmd_e                    cmd_q;
  logic [ID_BITS-1:0]      id_q;
  logic signed [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAX_W-1:0]        max_q;
  logic                    out_valid_q;
  logic [OUT_W-1:0]        out_data_q;

  logic                    accept;
  logic                    go;
  qctl_t                   qctl;
  logic [ID_BITS-1:0]      q_id;
  logic [ID_BITS-1:0]      head_id;
  logic                    q_empty;
  logic                    q_full;
  logic                    q_found;
  stat_e                   status;
  logic                    woken_valid;
  logic [ID_BITS-1:0]      woken_id;
  logic                    cnt_pos;
  logic                    cnt_neg;
  logic                    below_max;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign go            = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  assign cnt_pos   = (cnt_q > $signed(CNT_W'(0)));
  assign cnt_neg   = cnt_q[CNT_W-1];
  assign below_max = (cnt_q < $signed({1'b0, max_q}));

  // The cells compare against the incoming id on accept, and the latched id later.
  assign q_id = accept ? s_axis_tdata[CMD_W +: ID_BITS] : id_q;

  // Command decode: count update, queue control and the result fields.
  always_comb begin
    cnt_d       = cnt_q;
    status      = STAT_OK;
    woken_valid = 1'b0;
    woken_id    = '0;
    qctl        = '0;
    qctl.clear  = cfg_we_i && (cfg_idx_i == REG_INITIAL_COUNT);
    qctl.sample = accept;
    if (cfg_we_i && (cfg_idx_i == REG_INITIAL_COUNT)) begin
      cnt_d = $signed(cfg_data_i);
    end else if (go) begin
      case (cmd_q)
        CMD_POST: begin
          if (cnt_neg) begin
            status = STAT_NEG;
          end else if (!q_empty) begin
            woken_valid = 1'b1;
            woken_id    = head_id;
            qctl.pop    = 1'b1;
          end else if (below_max) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            status = STAT_ATMAX;
          end
        end
        CMD_WAIT: begin
          if (cnt_pos) begin
            cnt_d = cnt_q - CNT_W'(1);
          end else if (q_full) begin
            status = STAT_FULL;
          end else begin
            qctl.push = 1'b1;
            status    = STAT_QUEUED;
          end
        end
        CMD_TRY: begin
          if (cnt_pos) begin
            cnt_d = cnt_q - CNT_W'(1);
          end else begin
            status = STAT_NODATA;
          end
        end
        CMD_CANCEL: begin
          qctl.cancel = 1'b1;
          status      = q_found ? STAT_OK : STAT_NOTFOUND;
        end
        default: begin
          status = STAT_OK;
        end
      endcase
    end
  end

  // Sequencing between the compare cycle and the update cycle.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      max_q       <= MAX_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i && (cfg_idx_i == REG_MAX_COUNT)) begin
        max_q <= cfg_data_i[MAX_W-1:0];
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload and the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(s_axis_tdata[CMD_W-1:0]);
      id_q  <= s_axis_tdata[CMD_W +: ID_BITS];
    end
    if (go) begin
      out_data_q <= OUT_W'({cnt_d, woken_id, woken_valid, status});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  csfw_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (qctl),
    .id_i     (q_id),
    .head_id_o(head_id),
    .empty_o  (q_empty),
    .full_o   (q_full),
    .found_o  (q_found)
  );

endmodule
`default_nettype wire
